// ===== rtl/core/lsu_pkg.sv =====
// ----------------------------------------------------------------------------
// lsu_pkg: shared types and codes of the load/store unit
// Holds the request and response payloads, the command codes and the
// decoded operation that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package lsu_pkg;

  localparam logic [3:0] CMD_FSW = 4'd0;
  localparam logic [3:0] CMD_FLW = 4'd1;
  localparam logic [3:0] CMD_FSD = 4'd2;
  localparam logic [3:0] CMD_FLD = 4'd3;
  localparam logic [3:0] CMD_SB  = 4'd4;
  localparam logic [3:0] CMD_SH  = 4'd5;
  localparam logic [3:0] CMD_SW  = 4'd6;
  localparam logic [3:0] CMD_SD  = 4'd7;
  localparam logic [3:0] CMD_LB  = 4'd8;
  localparam logic [3:0] CMD_LBU = 4'd9;
  localparam logic [3:0] CMD_LH  = 4'd10;
  localparam logic [3:0] CMD_LHU = 4'd11;
  localparam logic [3:0] CMD_LW  = 4'd12;
  localparam logic [3:0] CMD_LWU = 4'd13;
  localparam logic [3:0] CMD_LD  = 4'd14;

  // Access size as log2 of the byte count.
  localparam logic [1:0] SIZE_B = 2'd0;
  localparam logic [1:0] SIZE_H = 2'd1;
  localparam logic [1:0] SIZE_W = 2'd2;
  localparam logic [1:0] SIZE_D = 2'd3;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_LOAD,
    OP_BAD
  } op_kind_t;

  typedef struct packed {
    logic [3:0]         command;
    logic [63:0]        base;
    logic signed [11:0] offset;
    logic [63:0]        store_data;
    logic [4:0]         dest_reg;
  } req_t;

  typedef struct packed {
    logic [4:0]  wb_reg;
    logic [63:0] wb_value;
    logic        bad_command;
  } rsp_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [1:0]  size;
    logic        sign_ext;
    logic [4:0]  dest_reg;
    logic [63:0] store_data;
  } op_t;

endpackage

// ===== rtl/core/rv64_load_store_unit.sv =====
// ----------------------------------------------------------------------------
// rv64_load_store_unit: RV64 load/store execution with private data memory
// Decode masks the address when MEM_BYTES is a power of two and reduces it
// in steps otherwise; the back end then walks the access one byte per cycle
// through the byte-wide memory, and skips the memory for an invalid command.
// A new request can be decoded while the back end still works on an earlier one.
// Reset: a clearing pass zeroes the memory; no item is accepted until it
// completes.
// ----------------------------------------------------------------------------
module rv64_load_store_unit #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lsu_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lsu_pkg::rsp_t rsp
);
  import lsu_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);

  // The front end decodes the command and reduces the effective address
  // modulo the memory size. For a power-of-two memory this is a mask; for
  // any other size each address bit adds its constant weight, eight bits per
  // cycle, and the compare-and-subtract states ST_FOLD_HI and ST_FOLD_LO
  // finish the remainder.
  logic          push_valid;
  logic          push_ready;
  op_t           push_op;
  logic [AW-1:0] push_addr;

  // The queue lets a new item be decoded while the back end is still busy
  // with an earlier one or while a finished response waits to be taken.
  logic          pop_valid;
  logic          pop_ready;
  op_t           pop_op;
  logic [AW-1:0] pop_addr;

  // High while the back end zeroes the memory after reset.
  logic          clearing;

  lsu_front #(
    .MEM_BYTES (MEM_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .hold       (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .push_addr  (push_addr)
  );

  lsu_queue #(
    .AW (AW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .push_addr  (push_addr),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op),
    .pop_addr   (pop_addr)
  );

  // The back end walks the bytes of each access in order, wrapping at the
  // end of memory, and holds the response in an output register so that a
  // stalled consumer does not stall decode.
  lsu_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .pop_addr  (pop_addr),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/core/lsu_front.sv =====
// ----------------------------------------------------------------------------
// lsu_front: request decode and address reduction
// Accepts a request, decodes the command, adds base and offset and reduces
// the sum modulo the memory size, then hands the operation to the queue.
// ----------------------------------------------------------------------------
module lsu_front #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  lsu_pkg::req_t                 req,
  input  logic                          hold,
  output logic                          push_valid,
  input  logic                          push_ready,
  output lsu_pkg::op_t                  push_op,
  output logic [$clog2(MEM_BYTES)-1:0]  push_addr
);
  import lsu_pkg::*;

  localparam int unsigned AW     = $clog2(MEM_BYTES);
  localparam bit          POW2   = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
  localparam int unsigned DIGITS = 8;
  localparam int unsigned ACC_W  = AW + 6;
  localparam logic [AW:0] MODULUS = (AW + 1)'(MEM_BYTES);
  localparam logic [ACC_W-1:0] MOD_ACC = ACC_W'(MEM_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FOLD_HI,
    ST_FOLD_LO,
    ST_PUSH
  } state_t;

  state_t           state;
  logic [63:0]      sum;
  logic [63:0]      shreg;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [ACC_W-1:0] pair [4];
  logic [ACC_W-1:0] fold_hi;
  logic [ACC_W-1:0] fold_lo;
  logic [AW-1:0]    weight [64];
  logic [2:0]       digit_cnt;
  op_t              op_dec;

  // Weight of address bit j: 2^j reduced modulo the memory size.
  function automatic logic [AW-1:0] pow2_mod(int unsigned j);
    logic [AW:0] r;
    r = (AW + 1)'(1);
    for (int unsigned i = 0; i < j; i++) begin
      r = r << 1;
      if (r >= MODULUS) begin
        r = r - MODULUS;
      end
    end
    return r[AW-1:0];
  endfunction

  for (genvar j = 0; j < 64; j++) begin : g_weight
    assign weight[j] = pow2_mod(j);
  end

  assign req_ready  = (state == ST_IDLE) && !hold;
  assign push_valid = (state == ST_PUSH);
  assign sum = req.base + {{52{req.offset[11]}}, req.offset};

  always_comb begin
    op_dec            = '0;
    op_dec.dest_reg   = req.dest_reg;
    op_dec.store_data = req.store_data;
    unique case (req.command) inside
      CMD_FSW, CMD_SW: begin
        op_dec.kind = OP_STORE;
        op_dec.size = SIZE_W;
      end
      CMD_FSD, CMD_SD: begin
        op_dec.kind = OP_STORE;
        op_dec.size = SIZE_D;
      end
      CMD_SB: begin
        op_dec.kind = OP_STORE;
        op_dec.size = SIZE_B;
      end
      CMD_SH: begin
        op_dec.kind = OP_STORE;
        op_dec.size = SIZE_H;
      end
      CMD_FLW, CMD_LWU: begin
        op_dec.kind = OP_LOAD;
        op_dec.size = SIZE_W;
      end
      CMD_FLD, CMD_LD: begin
        op_dec.kind = OP_LOAD;
        op_dec.size = SIZE_D;
      end
      CMD_LB: begin
        op_dec.kind     = OP_LOAD;
        op_dec.size     = SIZE_B;
        op_dec.sign_ext = 1'b1;
      end
      CMD_LBU: begin
        op_dec.kind = OP_LOAD;
        op_dec.size = SIZE_B;
      end
      CMD_LH: begin
        op_dec.kind     = OP_LOAD;
        op_dec.size     = SIZE_H;
        op_dec.sign_ext = 1'b1;
      end
      CMD_LHU: begin
        op_dec.kind = OP_LOAD;
        op_dec.size = SIZE_H;
      end
      CMD_LW: begin
        op_dec.kind     = OP_LOAD;
        op_dec.size     = SIZE_W;
        op_dec.sign_ext = 1'b1;
      end
      default: begin
        op_dec.kind = OP_BAD;
      end
    endcase
  end

  // Eight address bits per cycle, low byte first: every set bit adds its
  // weight, summed as a small tree.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pair[k] = (shreg[2*k] ? ACC_W'(weight[{digit_cnt, 3'(2*k)}]) : '0) +
                (shreg[2*k+1] ? ACC_W'(weight[{digit_cnt, 3'(2*k+1)}]) : '0);
    end
    acc_next = acc + ((pair[0] + pair[1]) + (pair[2] + pair[3]));
  end

  // The weighted sum stays below 64 times the memory size. Conditional
  // subtraction of 32, 16 and 8 times the size, then 4, 2 and 1 times it on
  // the next cycle, leaves the remainder.
  always_comb begin
    fold_hi = acc;
    for (int s = 5; s >= 3; s--) begin
      if (fold_hi >= (MOD_ACC << s)) begin
        fold_hi = fold_hi - (MOD_ACC << s);
      end
    end
    fold_lo = acc;
    for (int s = 2; s >= 0; s--) begin
      if (fold_lo >= (MOD_ACC << s)) begin
        fold_lo = fold_lo - (MOD_ACC << s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      digit_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid && req_ready) begin
            push_op   <= op_dec;
            shreg     <= sum;
            acc       <= '0;
            digit_cnt <= '0;
            if (POW2) begin
              push_addr <= sum[AW-1:0];
              state     <= ST_PUSH;
            end else begin
              state <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          acc       <= acc_next;
          shreg     <= {8'h00, shreg[63:8]};
          digit_cnt <= digit_cnt + 3'd1;
          if (digit_cnt == 3'(DIGITS - 1)) begin
            state <= ST_FOLD_HI;
          end
        end
        ST_FOLD_HI: begin
          acc   <= fold_hi;
          state <= ST_FOLD_LO;
        end
        ST_FOLD_LO: begin
          push_addr <= fold_lo[AW-1:0];
          state     <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/lsu_queue.sv =====
// ----------------------------------------------------------------------------
// lsu_queue: two-entry operation queue
// Decouples the decode front end from the memory back end.
// ----------------------------------------------------------------------------
module lsu_queue #(
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  lsu_pkg::op_t  push_op,
  input  logic [AW-1:0] push_addr,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lsu_pkg::op_t  pop_op,
  output logic [AW-1:0] pop_addr
);
  import lsu_pkg::*;

  op_t           ent_op   [2];
  logic [AW-1:0] ent_addr [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_op     = ent_op[rd_ptr];
  assign pop_addr   = ent_addr[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_op[wr_ptr]   <= push_op;
      ent_addr[wr_ptr] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/lsu_back.sv =====
// ----------------------------------------------------------------------------
// lsu_back: memory access sequencer
// Owns the byte-wide data memory, clears it after reset, walks each access
// one byte per cycle and builds the response.
// ----------------------------------------------------------------------------
module lsu_back #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  lsu_pkg::op_t                 pop_op,
  input  logic [$clog2(MEM_BYTES)-1:0] pop_addr,
  output logic                         clearing,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output lsu_pkg::rsp_t                rsp
);
  import lsu_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t        state;
  op_t           op;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] clr_addr;
  logic [2:0]    byte_idx;
  logic [2:0]    last_idx;
  logic          rd_valid;
  logic [2:0]    rd_idx;
  logic [7:0]    ld_bytes [8];
  logic [63:0]   ld_value;
  rsp_t          rsp_next;

  logic [7:0]    mem [MEM_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  assign clearing  = (state == ST_CLEAR);
  assign pop_ready = (state == ST_IDLE);
  assign last_idx  = 3'((4'd1 << op.size) - 4'd1);

  always_comb begin
    mem_we    = clearing || ((state == ST_ACCESS) && (op.kind == OP_STORE));
    mem_addr  = clearing ? clr_addr : cur_addr;
    mem_wdata = clearing ? 8'h00 : op.store_data[{byte_idx, 3'b000} +: 8];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      ld_bytes[rd_idx] <= mem_rdata;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ld_value[8*i +: 8] = ld_bytes[i];
    end
  end

  always_comb begin
    rsp_next = '0;
    case (op.kind)
      OP_LOAD: begin
        rsp_next.wb_reg = op.dest_reg;
        case (op.size)
          SIZE_B:  rsp_next.wb_value = {{56{op.sign_ext & ld_value[7]}}, ld_value[7:0]};
          SIZE_H:  rsp_next.wb_value = {{48{op.sign_ext & ld_value[15]}}, ld_value[15:0]};
          SIZE_W:  rsp_next.wb_value = {{32{op.sign_ext & ld_value[31]}}, ld_value[31:0]};
          default: rsp_next.wb_value = ld_value;
        endcase
      end
      OP_BAD: begin
        rsp_next.bad_command = 1'b1;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // A load byte read in this cycle is stored in the next cycle.
      rd_valid <= (state == ST_ACCESS) && (op.kind == OP_LOAD);
      // The response register refills as soon as the old one is taken.
      if ((state == ST_RESULT) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_valid) begin
            op       <= pop_op;
            cur_addr <= pop_addr;
            byte_idx <= '0;
            state    <= (pop_op.kind == OP_BAD) ? ST_RESULT : ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          cur_addr <= (cur_addr == LAST_ADDR) ? '0 : cur_addr + AW'(1);
          byte_idx <= byte_idx + 3'd1;
          rd_idx   <= byte_idx;
          if (byte_idx == last_idx) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp   <= rsp_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
